@@ hw/rtl/utf8v_pkg.sv @@
`default_nettype none
package utf8v_pkg;

  localparam longint unsigned MAX_LEN = 65536;
  localparam longint unsigned OFFSET_MAX = MAX_LEN - 1;
  localparam logic [15:0] OFFSET_LIMIT =
    (OFFSET_MAX > 64'hFFFF) ? 16'hFFFF : 16'(OFFSET_MAX);

  typedef logic [1:0] status_t;
  localparam status_t STATUS_VALID      = 2'd0;
  localparam status_t STATUS_INVALID    = 2'd1;
  localparam status_t STATUS_INCOMPLETE = 2'd2;

  localparam logic [20:0] NONCHAR_FFFE = 21'h00FFFE;
  localparam logic [20:0] NONCHAR_FFFF = 21'h00FFFF;

endpackage
`default_nettype wire

@@ hw/rtl/utf8v_in_if.sv @@
`default_nettype none
interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/utf8v_out_if.sv @@
`default_nettype none
interface utf8v_out_if;
  import utf8v_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] position;
  logic [1:0]  missing;

  modport source (output valid, output status, output position, output missing,
                  input ready);
  modport sink (input valid, input status, input position, input missing,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/utf8_stream_validator.sv @@
// A byte accepted into the input stage updates the decode state when it leaves that
//   stage; a byte with is_last loads the result register instead (two register stages).
// Throughput: one byte per cycle while the input does not stall; decode is combinational.
//   Input stalls only while a finished result waits and the staged byte is last.
// Reset (rst, synchronous, active high): empties both stages and clears all
//   decode state; the next byte starts a new string at offset 0.
`default_nettype none
module utf8_stream_validator (
  input  wire logic  clk,
  input  wire logic  rst,
  utf8v_in_if.sink   bytes,
  utf8v_out_if.source result
);
  import utf8v_pkg::*;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;

  // decode state
  logic [1:0]  bytes_owed, bytes_owed_next;
  logic [20:0] code_value, code_value_next;
  logic [15:0] char_start, char_start_next;
  logic [15:0] byte_offset;
  logic        error_seen, error_seen_next;
  logic        bad;

  // result register
  logic        out_valid;
  status_t     out_status;
  logic [15:0] out_position;
  logic [1:0]  out_missing;

  assign s1_fire     = s1_valid && (!s1_last || !out_valid || result.ready);
  assign bytes.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.data_byte;
      s1_last <= bytes.is_last;
    end
  end

  always_comb begin
    bytes_owed_next = bytes_owed;
    code_value_next = code_value;
    char_start_next = char_start;
    error_seen_next = error_seen;
    bad             = 1'b0;
    if (!error_seen) begin
      priority if (bytes_owed != 2'd0) begin
        if (s1_byte[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          code_value_next = {code_value[14:0], s1_byte[5:0]};
          bytes_owed_next = bytes_owed - 2'd1;
          if (bytes_owed_next == 2'd0 &&
              (code_value_next == NONCHAR_FFFE || code_value_next == NONCHAR_FFFF)) begin
            bad = 1'b1;
          end
        end
      end else if (s1_byte >= 8'hC2 && s1_byte <= 8'hDF) begin
        char_start_next = byte_offset;
        code_value_next = {16'd0, s1_byte[4:0]};
        bytes_owed_next = 2'd1;
      end else if (s1_byte[7:4] == 4'hE) begin
        char_start_next = byte_offset;
        code_value_next = {17'd0, s1_byte[3:0]};
        bytes_owed_next = 2'd2;
      end else if (s1_byte >= 8'hF0 && s1_byte <= 8'hF4) begin
        char_start_next = byte_offset;
        code_value_next = {18'd0, s1_byte[2:0]};
        bytes_owed_next = 2'd3;
      end else if (s1_byte[7] || (s1_byte < 8'h20 && s1_byte != 8'h09 &&
                                  s1_byte != 8'h0A && s1_byte != 8'h0D)) begin
        bad = 1'b1;
      end else begin
        bad = 1'b0;
      end
    end
    if (bad) begin
      error_seen_next = 1'b1;
      char_start_next = byte_offset;
      bytes_owed_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_owed  <= 2'd0;
      code_value  <= 21'd0;
      char_start  <= 16'd0;
      byte_offset <= 16'd0;
      error_seen  <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        bytes_owed  <= 2'd0;
        code_value  <= 21'd0;
        char_start  <= 16'd0;
        byte_offset <= 16'd0;
        error_seen  <= 1'b0;
      end else begin
        bytes_owed <= bytes_owed_next;
        code_value <= code_value_next;
        char_start <= char_start_next;
        error_seen <= error_seen_next;
        if (byte_offset < OFFSET_LIMIT) begin
          byte_offset <= byte_offset + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      priority if (error_seen_next) begin
        out_status   <= STATUS_INVALID;
        out_position <= char_start_next;
        out_missing  <= 2'd0;
      end else if (bytes_owed_next != 2'd0) begin
        out_status   <= STATUS_INCOMPLETE;
        out_position <= char_start_next;
        out_missing  <= bytes_owed_next;
      end else begin
        out_status   <= STATUS_VALID;
        out_position <= 16'd0;
        out_missing  <= 2'd0;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.status   = out_status;
  assign result.position = out_position;
  assign result.missing  = out_missing;

endmodule
`default_nettype wire

@@ hw/rtl/utf8v_checker.sv @@
`default_nettype none
module utf8v_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire utf8v_pkg::status_t    status,
  input wire logic [15:0]           position,
  input wire logic [1:0]            missing
);
  import utf8v_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_VALID || status == STATUS_INVALID ||
                   status == STATUS_INCOMPLETE))
    else $error("undefined status code");

  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_VALID |-> position == 16'd0 && missing == 2'd0)
    else $error("valid string with nonzero position or missing");

  a_bad_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_INVALID |-> missing == 2'd0)
    else $error("invalid string reports missing bytes");

  a_incomplete: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_INCOMPLETE |-> missing != 2'd0)
    else $error("incomplete string with nothing missing");

endmodule

bind utf8_stream_validator utf8v_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .status    (result.status),
  .position  (result.position),
  .missing   (result.missing)
);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import utf8v_pkg::*;

  localparam int RANDOM_BYTES = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 20;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } stim_t;

  typedef struct {
    status_t     status;
    logic [15:0] position;
    logic [1:0]  missing;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  utf8v_in_if  bytes_if ();
  utf8v_out_if result_if ();

  utf8_stream_validator u_top (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .result (result_if)
  );

  always #4 clk = ~clk;

  stim_t    pending[$];
  verdict_t verdicts[$];
  stim_t    cur_item;
  verdict_t want;

  bit loaded = 1'b0;
  bit sending = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit tx_calm = 1'b0;
  bit drain_next = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int next_hold = 0;
  int in_count = 0;
  int results_seen = 0;
  int fails = 0;

  // decoder state mirrored by the predictor
  logic [1:0]  owed = '0;
  logic [20:0] code_acc = '0;
  logic [15:0] char_at = '0;
  logic [15:0] offset = '0;
  logic        err_seen = 1'b0;

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic     bad;
    verdict_t v;
    bad = 1'b0;
    if (!err_seen) begin
      if (owed != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          code_acc = {code_acc[14:0], b[5:0]};
          owed = owed - 2'd1;
          if (owed == 2'd0 && (code_acc == NONCHAR_FFFE || code_acc == NONCHAR_FFFF))
            bad = 1'b1;
        end
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        char_at = offset;
        code_acc = {16'd0, b[4:0]};
        owed = 2'd1;
      end else if (b[7:4] == 4'hE) begin
        char_at = offset;
        code_acc = {17'd0, b[3:0]};
        owed = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        char_at = offset;
        code_acc = {18'd0, b[2:0]};
        owed = 2'd3;
      end else if (b > 8'h7F || (b < 8'h20 && b != 8'h09 && b != 8'h0A && b != 8'h0D)) begin
        bad = 1'b1;
      end
      if (bad) begin
        err_seen = 1'b1;
        char_at = offset;
        owed = 2'd0;
      end
    end
    if (!last) begin
      if (offset < OFFSET_LIMIT) offset = offset + 16'd1;
    end else begin
      if (err_seen) begin
        v.status = STATUS_INVALID;
        v.position = char_at;
        v.missing = 2'd0;
      end else if (owed != 2'd0) begin
        v.status = STATUS_INCOMPLETE;
        v.position = char_at;
        v.missing = owed;
      end else begin
        v.status = STATUS_VALID;
        v.position = 16'd0;
        v.missing = 2'd0;
      end
      verdicts.push_back(v);
      owed = '0;
      code_acc = '0;
      char_at = '0;
      offset = '0;
      err_seen = 1'b0;
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stim_t s;
    s.data = b;
    s.last = 1'b0;
    s.gap = tx_calm ? 0 : $urandom_range(0, 3);
    s.drain = drain_next;
    drain_next = 1'b0;
    pending.push_back(s);
  endtask

  // first byte sits in the most significant used lane
  task automatic push_seq(input logic [31:0] s, input int n);
    for (int i = n - 1; i >= 0; i--) push_byte(s[8*i +: 8]);
  endtask

  task automatic end_string();
    stim_t s;
    s = pending.pop_back();
    s.last = 1'b1;
    pending.push_back(s);
  endtask

  task automatic add_char(input bit cut);
    int         kind;
    int         conts;
    int         keep;
    logic [7:0] lead;
    kind = cut ? $urandom_range(5, 9) : $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        lead = 8'($urandom_range(8'h20, 8'h7F));
        conts = 0;
      end
      4: begin
        case ($urandom_range(0, 2))
          0: lead = 8'h09;
          1: lead = 8'h0A;
          default: lead = 8'h0D;
        endcase
        conts = 0;
      end
      5, 6: begin
        lead = 8'($urandom_range(8'hC2, 8'hDF));
        conts = 1;
      end
      7: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        conts = 2;
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        conts = 3;
      end
    endcase
    keep = cut ? $urandom_range(0, conts - 1) : conts;
    push_byte(lead);
    repeat (keep) push_byte(cont_byte());
  endtask

  // modes 0-4 clean, 5 lead without continuation, 6 noise byte,
  // 7 truncated tail, 8 noncharacter, 9 raw bytes
  task automatic add_string();
    int mode;
    int nchars;
    int spot;
    mode = $urandom_range(0, 9);
    nchars = $urandom_range(1, 8);
    spot = $urandom_range(0, nchars - 1);
    for (int i = 0; i < nchars; i++) begin
      if (i == spot && mode == 5) push_byte(8'($urandom_range(8'hC2, 8'hF4)));
      if (i == spot && mode == 6) push_byte(8'($urandom_range(0, 255)));
      if (i == spot && mode == 8)
        push_seq({8'h00, 16'hEFBF, ($urandom_range(0, 1) != 0) ? 8'hBF : 8'hBE}, 3);
      if (mode == 9) push_byte(8'($urandom_range(0, 255)));
      else add_char(mode == 7 && i == nchars - 1);
    end
    end_string();
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      bytes_if.valid <= 1'b0;
    end else begin
      if (in_taken) sending = 1'b0;
      if (!sending && !loaded && pending.size() != 0) begin
        cur_item = pending.pop_front();
        gap_left = cur_item.gap;
        loaded = 1'b1;
      end
      if (!sending && loaded && !(cur_item.drain && verdicts.size() != 0)) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          bytes_if.data_byte <= cur_item.data;
          bytes_if.is_last <= cur_item.last;
          sending = 1'b1;
          loaded = 1'b0;
        end
      end
      bytes_if.valid <= sending;
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (next_hold < 2 && in_count >= ((next_hold == 0) ? 300 : 1200)) begin
      hold_left <= HOLD_CYCLES;
      next_hold <= next_hold + 1;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (out_taken)
        stall_left = (((results_seen / 40) % 4) == 2) ? 0 : $urandom_range(0, 3);
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    in_taken <= !rst && bytes_if.valid && bytes_if.ready;
    out_taken <= !rst && result_if.valid && result_if.ready;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (verdicts.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: status %0d position %0d missing %0d",
                     result_if.status, result_if.position, result_if.missing);
        end else begin
          want = verdicts.pop_front();
          if (result_if.status !== want.status || result_if.position !== want.position ||
              result_if.missing !== want.missing) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: status %0d/%0d position %0d/%0d missing %0d/%0d (exp/act)",
                       want.status, result_if.status, want.position, result_if.position,
                       want.missing, result_if.missing);
          end
        end
      end
      if (bytes_if.valid && bytes_if.ready) begin
        in_count++;
        scan_byte(bytes_if.data_byte, bytes_if.is_last);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int str_idx;
    int base;
    bytes_if.valid = 1'b0;
    bytes_if.data_byte = 8'h00;
    bytes_if.is_last = 1'b0;
    result_if.ready = 1'b0;

    // allowed controls, DEL, overlong and surrogate forms, top four-byte lead
    push_seq(32'h090A0D7F, 4);
    push_seq(32'h00E08080, 3);
    push_seq(32'h00EDA080, 3);
    push_seq(32'hF4BFBFBF, 4);
    end_string();
    push_seq(32'h00EFBFBF, 3);
    end_string();
    // bad continuation, then bytes ignored until the end
    push_seq(32'h00C34100, 3);
    end_string();
    push_byte(8'hFF);
    end_string();
    // stray continuation on the last byte
    push_seq(32'h00002080, 2);
    end_string();
    push_seq(32'h0041F090, 3);
    end_string();
    push_byte(8'h1F);
    end_string();
    push_byte(8'hC0);
    end_string();

    base = pending.size();
    str_idx = 0;
    while (pending.size() - base < RANDOM_BYTES) begin
      tx_calm = ((str_idx / 20) % 4) == 1;
      drain_next = (str_idx % 90) == 89;
      add_string();
      str_idx++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || loaded || sending || verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
